@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define JHSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition holds on every clock edge out of reset.
`define JHSC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

@@ rtl/core/jhsc_pkg.sv @@
package jhsc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_HEIGHT = 1'd1;

    localparam logic [15:0] EXPECTED_WIDTH_RST  = 16'd640;
    localparam logic [15:0] EXPECTED_HEIGHT_RST = 16'd480;

    // Verdict codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_WRONG   = 3'd1;
    localparam logic [2:0] ST_NOTJPEG = 3'd2;
    localparam logic [2:0] ST_FORMAT  = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    // Marker bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOS    = 8'hDA;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } out_t;

    typedef struct packed {
        logic [15:0] expected_width;
        logic [15:0] expected_height;
    } cfg_t;

    // Input register to parser handshake
    typedef struct packed {
        logic valid;
        in_t  data;
    } stage_t;

endpackage

@@ rtl/core/jhsc_in_stage.sv @@
module jhsc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  jhsc_pkg::in_t   byte_data,
    input  logic            take,
    output jhsc_pkg::stage_t stage
);

    logic          valid_reg;
    logic          valid_next;
    jhsc_pkg::in_t data_reg;

    // hold while full and the parser cannot take the item
    assign byte_stall = valid_reg && !take;
    assign valid_next = byte_stall ? valid_reg : byte_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            data_reg <= byte_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

@@ rtl/core/jhsc_parser.sv @@
module jhsc_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  jhsc_pkg::cfg_t   cfg,
    input  jhsc_pkg::stage_t stage,
    output logic             take,
    output logic             advance,
    output logic             result_valid,
    input  logic             result_stall,
    output jhsc_pkg::out_t   result_data
);

    typedef enum logic [2:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MARK,
        PH_CODE,
        PH_LENH,
        PH_LENL,
        PH_SOFP,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] rem;
        logic        to_end;
    } skip_t;

    phase_t         phase_reg, phase_next;
    logic [7:0]     marker_code_reg, marker_code_next;
    logic [7:0]     length_high_reg, length_high_next;
    logic [2:0]     payload_index_reg, payload_index_next;
    logic [15:0]    skip_remaining_reg, skip_remaining_next;
    logic           skip_to_end_reg, skip_to_end_next;
    logic [15:0]    held_width_reg, held_width_next;
    logic [15:0]    held_height_reg, held_height_next;
    logic           verdict_given_reg, verdict_given_next;
    logic           result_valid_reg, result_valid_next;
    jhsc_pkg::out_t result_data_reg, result_data_next;

    logic           emit;
    logic [2:0]     emit_status;
    logic [7:0]     b;
    logic [15:0]    seg_len;
    logic [2:0]     idx_inc;
    skip_t          sk_hdr;
    skip_t          sk_sof;

    function automatic logic is_sof(input logic [7:0] c);
        is_sof = c inside {[8'hC0:8'hC3], [8'hC5:8'hC7], [8'hC9:8'hCB], [8'hCD:8'hCF]};
    endfunction

    // Leave a segment header or SOF payload: skip what is left of the segment.
    function automatic skip_t start_skip(input logic [15:0] len, input logic [15:0] used,
                                         input logic [15:0] cur_rem);
        skip_t s;
        s.phase  = PH_SKIP;
        s.rem    = cur_rem;
        s.to_end = 1'b0;
        if (len < used)
        begin
            s.to_end = 1'b1;
        end
        else if (len == used)
        begin
            s.phase = PH_MARK;
        end
        else
        begin
            s.rem = len - used;
        end
        return s;
    endfunction

    assign take    = !result_valid_reg || !result_stall;
    assign advance = stage.valid && take;

    assign b       = stage.data.data_byte;
    assign seg_len = {length_high_reg, b};
    assign idx_inc = payload_index_reg + 3'd1;
    assign sk_hdr  = start_skip(seg_len, 16'd2, skip_remaining_reg);
    assign sk_sof  = start_skip(skip_remaining_reg, 16'd7, skip_remaining_reg);

    always_comb
    begin
        phase_next          = phase_reg;
        marker_code_next    = marker_code_reg;
        length_high_next    = length_high_reg;
        payload_index_next  = payload_index_reg;
        skip_remaining_next = skip_remaining_reg;
        skip_to_end_next    = skip_to_end_reg;
        held_width_next     = held_width_reg;
        held_height_next    = held_height_reg;
        verdict_given_next  = verdict_given_reg;
        emit                = 1'b0;
        emit_status         = jhsc_pkg::ST_OK;

        if (!verdict_given_reg)
        begin
            case (phase_reg)
                PH_SOI0:
                begin
                    marker_code_next = b;
                    phase_next       = PH_SOI1;
                end
                PH_SOI1:
                begin
                    if (marker_code_reg == jhsc_pkg::MARK_PREFIX && b == jhsc_pkg::MARK_SOI)
                    begin
                        marker_code_next = 8'd0;
                        phase_next       = PH_MARK;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = jhsc_pkg::ST_NOTJPEG;
                    end
                end
                PH_MARK:
                begin
                    payload_index_next = {2'b00, b != jhsc_pkg::MARK_PREFIX};
                    phase_next         = PH_CODE;
                end
                PH_CODE:
                begin
                    marker_code_next = b;
                    phase_next       = PH_LENH;
                end
                PH_LENH:
                begin
                    length_high_next = b;
                    phase_next       = PH_LENL;
                end
                PH_LENL:
                begin
                    if (payload_index_reg[0])
                    begin
                        emit        = 1'b1;
                        emit_status = jhsc_pkg::ST_FORMAT;
                    end
                    else if (marker_code_reg == jhsc_pkg::MARK_SOS)
                    begin
                        emit        = 1'b1;
                        emit_status = (held_width_reg == cfg.expected_width &&
                                       held_height_reg == cfg.expected_height)
                                      ? jhsc_pkg::ST_OK : jhsc_pkg::ST_WRONG;
                    end
                    else if (is_sof(marker_code_reg))
                    begin
                        skip_remaining_next = seg_len;
                        payload_index_next  = 3'd0;
                        phase_next          = PH_SOFP;
                    end
                    else
                    begin
                        phase_next          = sk_hdr.phase;
                        skip_remaining_next = sk_hdr.rem;
                        skip_to_end_next    = skip_to_end_reg | sk_hdr.to_end;
                    end
                end
                PH_SOFP:
                begin
                    case (payload_index_reg)
                        3'd1: held_height_next = {b, held_height_reg[7:0]};
                        3'd2: held_height_next = {held_height_reg[15:8], b};
                        3'd3: held_width_next  = {b, held_width_reg[7:0]};
                        3'd4: held_width_next  = {held_width_reg[15:8], b};
                        default: ;
                    endcase
                    payload_index_next = idx_inc;
                    if (idx_inc >= 3'd5)
                    begin
                        payload_index_next  = 3'd0;
                        phase_next          = sk_sof.phase;
                        skip_remaining_next = sk_sof.rem;
                        skip_to_end_next    = skip_to_end_reg | sk_sof.to_end;
                    end
                end
                PH_SKIP:
                begin
                    if (!skip_to_end_reg)
                    begin
                        skip_remaining_next = skip_remaining_reg - 16'd1;
                        if (skip_remaining_reg == 16'd1)
                        begin
                            phase_next = PH_MARK;
                        end
                    end
                end
                default:
                begin
                    phase_next       = PH_SKIP;
                    skip_to_end_next = 1'b1;
                end
            endcase
        end

        if (emit)
        begin
            verdict_given_next = 1'b1;
        end

        // end of file: flag truncation if still open, then re-arm
        if (stage.data.end_of_file)
        begin
            if (!verdict_given_next)
            begin
                emit        = 1'b1;
                emit_status = jhsc_pkg::ST_TRUNC;
            end
            phase_next          = PH_SOI0;
            marker_code_next    = 8'd0;
            length_high_next    = 8'd0;
            payload_index_next  = 3'd0;
            skip_remaining_next = 16'd0;
            skip_to_end_next    = 1'b0;
            held_width_next     = 16'd0;
            held_height_next    = 16'd0;
            verdict_given_next  = 1'b0;
        end
    end

    always_comb
    begin
        result_data_next.status = emit_status;
        if (emit_status == jhsc_pkg::ST_OK || emit_status == jhsc_pkg::ST_WRONG)
        begin
            result_data_next.image_width  = held_width_reg;
            result_data_next.image_height = held_height_reg;
        end
        else
        begin
            result_data_next.image_width  = 16'd0;
            result_data_next.image_height = 16'd0;
        end

        if (advance)
        begin
            result_valid_next = emit;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_SOI0;
            marker_code_reg    <= 8'd0;
            length_high_reg    <= 8'd0;
            payload_index_reg  <= 3'd0;
            skip_remaining_reg <= 16'd0;
            skip_to_end_reg    <= 1'b0;
            held_width_reg     <= 16'd0;
            held_height_reg    <= 16'd0;
            verdict_given_reg  <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg          <= phase_next;
                marker_code_reg    <= marker_code_next;
                length_high_reg    <= length_high_next;
                payload_index_reg  <= payload_index_next;
                skip_remaining_reg <= skip_remaining_next;
                skip_to_end_reg    <= skip_to_end_next;
                held_width_reg     <= held_width_next;
                held_height_reg    <= held_height_next;
                verdict_given_reg  <= verdict_given_next;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            result_data_reg <= result_data_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

@@ rtl/core/jpeg_header_size_checker.sv @@
// Channel   Direction  Handshake                   Payload
// byte      in         byte_valid / byte_stall     byte_data   (data_byte, end_of_file)
// result    out        result_valid / result_stall result_data (status, width, height)
// cfg       in         cfg_wr_en                   cfg_index, cfg_wdata
//
// One byte is taken per cycle while the result side does not stall; a verdict
// passes from the input register through the parser into the result register.
// Throughput is set by the single parser state update per byte: one byte a cycle when not stalled.
// Reset (rst_n, asynchronous) clears the parser and loads 640 x 480 as the size.
// A stalled result holds the parser; the input register then fills and
// byte_stall rises, so no byte is dropped.

`include "assert_macros.svh"

module jpeg_header_size_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    output logic                           byte_stall,
    input  jhsc_pkg::in_t                  byte_data,
    output logic                           result_valid,
    input  logic                           result_stall,
    output jhsc_pkg::out_t                 result_data,
    input  logic                           cfg_wr_en,
    input  logic [jhsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_wdata
);

    jhsc_pkg::cfg_t   cfg_reg;
    jhsc_pkg::stage_t stage;
    logic             take;
    logic             advance;

    // Size registers: the user writes them only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_width  <= jhsc_pkg::EXPECTED_WIDTH_RST;
            cfg_reg.expected_height <= jhsc_pkg::EXPECTED_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                jhsc_pkg::CFG_EXPECTED_WIDTH:  cfg_reg.expected_width  <= cfg_wdata;
                jhsc_pkg::CFG_EXPECTED_HEIGHT: cfg_reg.expected_height <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: parts the byte source from the parser.
    jhsc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .take       (take),
        .stage      (stage)
    );

    // Marker walk and verdict, with the result register behind it.
    jhsc_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .stage        (stage),
        .take         (take),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // A verdict without a size carries zero dimensions.
    `JHSC_ASSERT(a_unsized_zero,
        result_valid && (result_data.status == jhsc_pkg::ST_NOTJPEG ||
        result_data.status == jhsc_pkg::ST_FORMAT ||
        result_data.status == jhsc_pkg::ST_TRUNC)
        |-> result_data.image_width == 16'd0 && result_data.image_height == 16'd0,
        "unsized verdict carries a size")

    // A fresh result only ever follows a byte moving into the parser.
    `JHSC_ASSERT(a_result_from_byte,
        result_valid && !$past(result_valid && result_stall) |-> $past(advance),
        "result appeared without a byte transfer")

    // Stall the source only while the input register holds a byte.
    `JHSC_ASSERT_ALWAYS(a_stall_when_full, !byte_stall || stage.valid,
        "byte_stall raised with empty input register")

endmodule

@@ sim/tb_jpeg_header_size_checker.sv @@
module tb_jpeg_header_size_checker;

    // Cycles with no transfer on any port before the run is declared hung.
    // The longest quiet stretch of a correct run is the long result hold
    // (LONG_HOLD); everything else is a random stall burst or sender gap.
    localparam int unsigned HANG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD  = 400;
    localparam int unsigned BYTES_PER_SETTING = 300;

    // Where the header walk stands between bytes.
    typedef enum logic [3:0] {
        AWAIT_SOI_FF,
        AWAIT_SOI_D8,
        AWAIT_PREFIX,
        AWAIT_CODE,
        AWAIT_LEN_HI,
        AWAIT_LEN_LO,
        READ_FRAME,
        SKIP_BODY
    } walk_e;

    // Predicts the verdict of each file from the bytes transferred in and
    // matches it against the results that come out.
    class jpeg_size_board;
        logic [15:0]      want_width;
        logic [15:0]      want_height;
        walk_e            walk;
        logic [7:0]       code;
        logic [7:0]       len_hi;
        bit               bad_prefix;
        int               frame_idx;
        logic [15:0]      remaining;
        bit               skip_all;
        logic [15:0]      seen_width;
        logic [15:0]      seen_height;
        bit               decided;
        jhsc_pkg::out_t   pending_verdicts[$];
        int               mismatches;

        function new();
            want_width  = jhsc_pkg::EXPECTED_WIDTH_RST;
            want_height = jhsc_pkg::EXPECTED_HEIGHT_RST;
            mismatches  = 0;
            restart();
        endfunction

        function void set_size(logic [15:0] w, logic [15:0] h);
            want_width  = w;
            want_height = h;
        endfunction

        // Back to the start-of-image search; the size registers stay.
        function void restart();
            walk        = AWAIT_SOI_FF;
            code        = '0;
            len_hi      = '0;
            bad_prefix  = 1'b0;
            frame_idx   = 0;
            remaining   = '0;
            skip_all    = 1'b0;
            seen_width  = '0;
            seen_height = '0;
            decided     = 1'b0;
        endfunction

        // Start-of-frame codes: C0 to CF less DHT (C4), JPG (C8) and DAC (CC).
        function bit is_frame_code(logic [7:0] c);
            return c[7:4] == 4'hC && c != 8'hC4 && c != 8'hC8 && c != 8'hCC;
        endfunction

        // Skip what is left of a segment once 'used' of its length is spent.
        function void begin_skip(logic [15:0] len, logic [15:0] used);
            if (len < used)
            begin
                skip_all = 1'b1;
                walk     = SKIP_BODY;
            end
            else if (len == used)
            begin
                walk = AWAIT_PREFIX;
            end
            else
            begin
                remaining = len - used;
                walk      = SKIP_BODY;
            end
        endfunction

        function void post(logic [2:0] st);
            jhsc_pkg::out_t v;
            bit             sized;
            sized          = (st == jhsc_pkg::ST_OK) || (st == jhsc_pkg::ST_WRONG);
            v.status       = st;
            v.image_width  = sized ? seen_width : 16'd0;
            v.image_height = sized ? seen_height : 16'd0;
            pending_verdicts.push_back(v);
            decided = 1'b1;
        endfunction

        function void note_byte(jhsc_pkg::in_t item);
            logic [7:0]  b;
            logic [15:0] seg_len;
            b       = item.data_byte;
            seg_len = {len_hi, b};
            if (!decided)
            begin
                case (walk)
                    AWAIT_SOI_FF:
                    begin
                        code = b;
                        walk = AWAIT_SOI_D8;
                    end
                    AWAIT_SOI_D8:
                    begin
                        if (code == jhsc_pkg::MARK_PREFIX && b == jhsc_pkg::MARK_SOI)
                        begin
                            code = '0;
                            walk = AWAIT_PREFIX;
                        end
                        else
                        begin
                            post(jhsc_pkg::ST_NOTJPEG);
                        end
                    end
                    AWAIT_PREFIX:
                    begin
                        // Judged only once the whole segment header is in.
                        bad_prefix = (b != jhsc_pkg::MARK_PREFIX);
                        walk       = AWAIT_CODE;
                    end
                    AWAIT_CODE:
                    begin
                        code = b;
                        walk = AWAIT_LEN_HI;
                    end
                    AWAIT_LEN_HI:
                    begin
                        len_hi = b;
                        walk   = AWAIT_LEN_LO;
                    end
                    AWAIT_LEN_LO:
                    begin
                        if (bad_prefix)
                        begin
                            post(jhsc_pkg::ST_FORMAT);
                        end
                        else if (code == jhsc_pkg::MARK_SOS)
                        begin
                            // Start of scan decides, whatever its length.
                            if (seen_width == want_width && seen_height == want_height)
                                post(jhsc_pkg::ST_OK);
                            else
                                post(jhsc_pkg::ST_WRONG);
                        end
                        else if (is_frame_code(code))
                        begin
                            remaining = seg_len;
                            frame_idx = 0;
                            walk      = READ_FRAME;
                        end
                        else
                        begin
                            begin_skip(seg_len, 16'd2);
                        end
                    end
                    READ_FRAME:
                    begin
                        // Precision, then height and width, both big-endian.
                        case (frame_idx)
                            1: seen_height[15:8] = b;
                            2: seen_height[7:0]  = b;
                            3: seen_width[15:8]  = b;
                            4: seen_width[7:0]   = b;
                            default: ;
                        endcase
                        frame_idx++;
                        if (frame_idx == 5)
                        begin
                            frame_idx = 0;
                            begin_skip(remaining, 16'd7);
                        end
                    end
                    SKIP_BODY:
                    begin
                        if (!skip_all)
                        begin
                            remaining = remaining - 16'd1;
                            if (remaining == 16'd0)
                                walk = AWAIT_PREFIX;
                        end
                    end
                    default:
                    begin
                        walk     = SKIP_BODY;
                        skip_all = 1'b1;
                    end
                endcase
            end
            // The last byte counts first; a file with no verdict is truncated.
            if (item.end_of_file)
            begin
                if (!decided)
                    post(jhsc_pkg::ST_TRUNC);
                restart();
            end
        endfunction

        function void check_result(jhsc_pkg::out_t got);
            jhsc_pkg::out_t want;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d width %0d height %0d",
                             got.status, got.image_width, got.image_height);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.status !== want.status || got.image_width !== want.image_width ||
                    got.image_height !== want.image_height)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: status %0d/%0d width %0d/%0d ",
                                  "height %0d/%0d"},
                                 want.status, got.status, want.image_width, got.image_width,
                                 want.image_height, got.image_height);
                end
            end
        endfunction
    endclass

    logic           clk          = 1'b0;
    logic           rst_n        = 1'b0;
    logic           byte_valid   = 1'b0;
    logic           byte_stall;
    jhsc_pkg::in_t  byte_data    = '0;
    logic           result_valid;
    logic           result_stall = 1'b0;
    jhsc_pkg::out_t result_data;
    logic           cfg_wr_en    = 1'b0;
    logic [jhsc_pkg::CFG_IDX_W-1:0] cfg_index = jhsc_pkg::CFG_EXPECTED_WIDTH;
    logic [15:0]    cfg_wdata    = '0;

    jpeg_size_board sb = new();

    // Test state; calm and hold_left are shared between the stimulus and the result side.
    bit          calm      = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_run = 0;
    int unsigned phase_bytes;
    logic [7:0]  fbuf[$];

    const logic [7:0] frame_codes[13] = '{8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hC7,
                                          8'hC9, 8'hCA, 8'hCB, 8'hCD, 8'hCE, 8'hCF};

    jpeg_header_size_checker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Result side: check every transfer, then choose the next stall. A long
    // hold, when requested, takes priority over the random bursts.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_data);
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Hang guard: count cycles in which nothing moves on any port.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall) || cfg_wr_en)
            begin
                quiet_run = 0;
            end
            else
            begin
                quiet_run++;
                if (quiet_run >= HANG_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Offer one byte and hold it until the block takes it. Valid stays high
    // afterwards; the caller decides whether the next cycle is a gap.
    task automatic send_byte(input jhsc_pkg::in_t item);
        byte_valid <= 1'b1;
        byte_data  <= item;
        do
            @(posedge clk);
        while (byte_stall);
        sb.note_byte(item);
    endtask

    task automatic sender_gap(input int unsigned n);
        byte_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Pause the byte side until every predicted verdict has been transferred.
    task automatic drain();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_verdicts.size() != 0);
    endtask

    task automatic send_file();
        jhsc_pkg::in_t item;
        for (int i = 0; i < fbuf.size(); i++)
        begin
            item.data_byte   = fbuf[i];
            item.end_of_file = (i == fbuf.size() - 1);
            send_byte(item);
            phase_bytes++;
            if (!calm && $urandom_range(0, 9) == 0)
                sender_gap($urandom_range(1, 14));
        end
    endtask

    // Only called with the block idle and the last file closed.
    task automatic write_size(input logic [15:0] w, input logic [15:0] h);
        cfg_wr_en <= 1'b1;
        cfg_index <= jhsc_pkg::CFG_EXPECTED_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_index <= jhsc_pkg::CFG_EXPECTED_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_size(w, h);
    endtask

    function automatic void add_header(logic [7:0] c, logic [15:0] len);
        fbuf.push_back(jhsc_pkg::MARK_PREFIX);
        fbuf.push_back(c);
        fbuf.push_back(len[15:8]);
        fbuf.push_back(len[7:0]);
    endfunction

    function automatic void add_noise(int unsigned n);
        repeat (n) fbuf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // The configured value, an edge value, a random one or a near miss by
    // one bit, each equally likely.
    function automatic logic [15:0] pick_dim(logic [15:0] want);
        case ($urandom_range(0, 3))
            0: return want;
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: return 16'($urandom_range(0, 65535));
            default: return want ^ (16'd1 << $urandom_range(0, 15));
        endcase
    endfunction

    function automatic void add_frame();
        logic [15:0] len;
        logic [15:0] h;
        logic [15:0] w;
        bit          exact;
        len   = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(0, 6))
                                             : 16'($urandom_range(7, 12));
        exact = $urandom_range(0, 1);
        h     = exact ? sb.want_height : pick_dim(sb.want_height);
        w     = exact ? sb.want_width : pick_dim(sb.want_width);
        add_header(frame_codes[$urandom_range(0, 12)], len);
        fbuf.push_back(8'($urandom_range(0, 255)));
        fbuf.push_back(h[15:8]);
        fbuf.push_back(h[7:0]);
        fbuf.push_back(w[15:8]);
        fbuf.push_back(w[7:0]);
        if (len > 7)
            add_noise(len - 7);
    endfunction

    // Build one random file: mostly well-formed marker walks, some with a
    // corrupted or cut-off byte stream, and a few of plain noise.
    function automatic void build_file();
        int unsigned pick;
        int unsigned keep;
        int unsigned pos;
        logic [7:0]  c;
        logic [15:0] len;
        bit          cut;
        fbuf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            if ($urandom_range(0, 1))
            begin
                fbuf.push_back(jhsc_pkg::MARK_PREFIX);
                fbuf.push_back(jhsc_pkg::MARK_SOI);
            end
            add_noise($urandom_range(1, 12));
            return;
        end
        fbuf.push_back(jhsc_pkg::MARK_PREFIX);
        fbuf.push_back(jhsc_pkg::MARK_SOI);
        cut = 1'b0;
        for (int s = $urandom_range(0, 4); s > 0 && !cut; s--)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                add_frame();
            end
            else
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (sb.is_frame_code(c) || c == jhsc_pkg::MARK_SOS);
                if ($urandom_range(0, 24) == 0)
                begin
                    // Any length at all; the file ends after at most 6 body bytes.
                    add_header(c, 16'($urandom_range(0, 65535)));
                    add_noise($urandom_range(0, 6));
                    cut = 1'b1;
                end
                else
                begin
                    len = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(0, 1))
                                                       : 16'($urandom_range(2, 9));
                    add_header(c, len);
                    if (len > 2)
                        add_noise(len - 2);
                end
            end
        end
        if (!cut && $urandom_range(0, 9) != 0)
        begin
            add_header(jhsc_pkg::MARK_SOS, 16'($urandom_range(0, 65535)));
            add_noise($urandom_range(0, 4));
        end
        if (pick < 30)
        begin
            pos       = $urandom_range(0, fbuf.size() - 1);
            fbuf[pos] = 8'($urandom_range(0, 255));
        end
        else if (pick < 40)
        begin
            keep = $urandom_range(1, fbuf.size());
            while (fbuf.size() > keep)
                void'(fbuf.pop_back());
        end
    endfunction

    task automatic run_random(input int unsigned budget);
        phase_bytes = 0;
        while (phase_bytes < budget)
        begin
            build_file();
            send_file();
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    initial
    begin
        logic [15:0] w;
        logic [15:0] h;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files under the reset size of 640 x 480.
        // Clean file, matching size; verdict on the scan length byte.
        fbuf = {8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h07, 8'h08, 8'h01, 8'hE0,
                8'h02, 8'h80, 8'hFF, 8'hDA, 8'h00, 8'h0C};
        send_file();
        // End of file on the very first byte.
        fbuf = {8'h00};
        send_file();
        // Wrong start-of-image pair; what follows is ignored.
        fbuf = {8'h47, 8'hD9, 8'hFF, 8'hD8};
        send_file();
        // Segment not opened by FF.
        fbuf = {8'hFF, 8'hD8, 8'h12, 8'hDA, 8'h00, 8'h02};
        send_file();
        // Length below 2 on an ordinary segment: skip to the end.
        fbuf = {8'hFF, 8'hD8, 8'hFF, 8'hC4, 8'h00, 8'h01, 8'hAA};
        send_file();
        // Frame header with a length below 7: the scan marker is skipped too.
        fbuf = {8'hFF, 8'hD8, 8'hFF, 8'hCF, 8'h00, 8'h03, 8'h08, 8'hFF, 8'hFF,
                8'h00, 8'h01, 8'hFF, 8'hDA, 8'h00, 8'h02};
        send_file();
        // Two frame headers, the last one (height FFFF, width 0) wins.
        fbuf = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h04, 8'h55, 8'h66,
                8'hFF, 8'hC2, 8'h00, 8'h07, 8'h08, 8'h01, 8'hE0, 8'h02, 8'h80,
                8'hFF, 8'hC9, 8'h00, 8'h08, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h77,
                8'hFF, 8'hDA, 8'h00, 8'h00};
        send_file();
        // End of file inside a segment header.
        fbuf = {8'hFF, 8'hD8, 8'hFF};
        send_file();

        run_random(BYTES_PER_SETTING);

        // Several size settings, extremes first; the last one runs without
        // random result stalls or sender gaps.
        for (int p = 1; p <= 5; p++)
        begin
            drain();
            repeat (6) @(posedge clk);
            case (p)
                1:
                begin
                    w = 16'h0000;
                    h = 16'h0000;
                end
                2:
                begin
                    w = 16'hFFFF;
                    h = 16'hFFFF;
                end
                3:
                begin
                    w = 16'hFFFF;
                    h = 16'h0000;
                end
                4:
                begin
                    w = 16'($urandom_range(0, 65535));
                    h = 16'($urandom_range(0, 65535));
                end
                default:
                begin
                    w = jhsc_pkg::EXPECTED_WIDTH_RST;
                    h = jhsc_pkg::EXPECTED_HEIGHT_RST;
                end
            endcase
            write_size(w, h);
            if (p == 2)
                hold_left = LONG_HOLD;  // keep offering bytes while results back up
            if (p == 5)
                calm = 1'b1;
            run_random(BYTES_PER_SETTING);
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ jpeg_header_size_checker.f @@
+incdir+rtl/core
rtl/core/jhsc_pkg.sv
rtl/core/jhsc_in_stage.sv
rtl/core/jhsc_parser.sv
rtl/core/jpeg_header_size_checker.sv
sim/tb_jpeg_header_size_checker.sv
